FILE: rtl/sst_pkg.sv
// Shared types and constants for the slot set table.
`default_nettype none

package sst_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int OUT_DATA_W   = 40;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_MEMBER = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR
    } state_t;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic               load;
        logic               do_append;
        logic               do_remove;
        logic               shift;
        logic               pref_hit;
        logic [VALUE_W-1:0] cmp_key;
        logic [VALUE_W-1:0] store_key;
    } sst_ctrl_t;

    // Travels from a cell to the next higher index.
    typedef struct packed {
        logic free_seen;
        logic match_seen;
    } sst_up_t;

    // Travels from a cell to the next lower index.
    typedef struct packed {
        logic               any_used;
        logic               used;
        logic [VALUE_W-1:0] value;
    } sst_dn_t;

endpackage

`default_nettype wire

FILE: rtl/sst_cell.sv
// One slot of the table: value, occupied mark and match flag.
`default_nettype none

module sst_cell
    import sst_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire sst_ctrl_t ctrl,
    input  wire logic      pref_slot,
    input  wire sst_up_t   up_in,
    output      sst_up_t   up_out,
    input  wire sst_dn_t   dn_in,
    output      sst_dn_t   dn_out
);

    logic               used_reg;
    logic               used_next;
    logic               match_reg;
    logic               match_next;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic               take;
    logic               drop;

    // The lowest free slot is taken unless the slot at the count is free.
    assign take = ctrl.do_append
                  & (ctrl.pref_hit ? pref_slot : (~used_reg & ~up_in.free_seen));
    assign drop = ctrl.do_remove & match_reg & ~up_in.match_seen;

    assign up_out.free_seen  = up_in.free_seen | ~used_reg;
    assign up_out.match_seen = up_in.match_seen | match_reg;

    assign dn_out.any_used = used_reg | dn_in.any_used;
    assign dn_out.used     = used_reg;
    assign dn_out.value    = value_reg;

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.load)
        begin
            match_next = used_reg & (value_reg == ctrl.cmp_key);
        end

        used_next  = used_reg;
        value_next = value_reg;
        if (ctrl.shift)
        begin
            used_next  = dn_in.used;
            value_next = dn_in.value;
        end
        else if (take)
        begin
            used_next  = 1'b1;
            value_next = ctrl.store_key;
        end
        else if (drop)
        begin
            used_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            used_reg  <= used_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

FILE: rtl/slot_set_table.sv
// Top level of the slot set table: sequencer, row of slot cells and result register.
`default_nettype none

// The table is a row of CAPACITY slot cells, each holding one value and its
// occupied mark. A request carries an action in tuser and a value in tdata.
// For append, remove and member test, every cell compares its value with the
// key in the cycle the request is accepted; then, once the output register
// is free, a ripple chain through the cells picks the lowest matching slot
// (for append, the slot at the count if free, else the lowest free slot) and
// the single result goes to the output register. Clear accepts the request
// and looks at the table, then streams the table down the row one cell per
// cycle while the output register is free, ending on the highest occupied
// slot; released values leave in index order with tlast on the final one,
// and a clear of an empty table gives one all-zero result with tlast set.
// A new request is accepted once the previous one has been handed to the
// output register, even if that result has not yet been taken. Stalls on the
// output side hold the sequencer without losing or repeating results.

module slot_set_table
    import sst_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // s_axis_tdata: value[31:0]
    input  wire logic [VALUE_W-1:0]    s_axis_tdata,
    // s_axis_tuser: action[1:0]
    input  wire logic [1:0]            s_axis_tuser,
    input  wire logic                  s_axis_tvalid,
    output      logic                  s_axis_tready,
    // m_axis_tdata: status[0], is_member[1], released_value[33:2], zero fill
    output      logic [OUT_DATA_W-1:0] m_axis_tdata,
    // m_axis_tuser: released_valid[0]
    output      logic                  m_axis_tuser,
    output      logic                  m_axis_tlast,
    output      logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready
);

    localparam int CW = $clog2(CAPACITY + 1);

    state_t             state_reg;
    state_t             state_next;
    action_t            action_reg;
    logic [VALUE_W-1:0] key_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;

    logic               out_valid_reg;
    logic               out_status_reg;
    logic               out_member_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_rel_valid_reg;
    logic               out_last_reg;

    logic               emit;
    logic               emit_status;
    logic               emit_member;
    logic [VALUE_W-1:0] emit_value;
    logic               emit_rel_valid;
    logic               emit_last;

    logic               accept;
    logic               out_free;
    logic               has_room;
    logic               found;
    logic               rest_any;

    sst_ctrl_t          ctrl;
    sst_up_t            up_link [CAPACITY+1];
    sst_dn_t            dn_link [CAPACITY+1];
    logic [CAPACITY-1:0] pref_vec;
    logic [CAPACITY-1:0] used_vec;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign out_free      = ~out_valid_reg | m_axis_tready;
    assign has_room      = (count_reg < CW'(CAPACITY));
    assign found         = up_link[CAPACITY].match_seen;
    // Occupied slots above cell zero; none means cell zero is the last to go.
    assign rest_any      = dn_link[1].any_used;

    // The row of cells. Search chains run upwards, the clear stream downwards.
    assign up_link[0]        = '0;
    assign dn_link[CAPACITY] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign pref_vec[i] = (count_reg == CW'(i));
        assign used_vec[i] = dn_link[i].used;

        sst_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .pref_slot (pref_vec[i]),
            .up_in     (up_link[i]),
            .up_out    (up_link[i+1]),
            .dn_in     (dn_link[i+1]),
            .dn_out    (dn_link[i])
        );
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    if ((action_reg == ACT_CLEAR) && dn_link[0].any_used)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CLEAR:
            begin
                if (out_free && dn_link[0].used && !rest_any)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Cell commands, count update and the result to be registered.
    always_comb
    begin
        ctrl.load      = accept;
        ctrl.do_append = 1'b0;
        ctrl.do_remove = 1'b0;
        ctrl.shift     = 1'b0;
        ctrl.pref_hit  = |(pref_vec & ~used_vec);
        ctrl.cmp_key   = s_axis_tdata;
        ctrl.store_key = key_reg;

        count_next     = count_reg;
        emit           = 1'b0;
        emit_status    = 1'b0;
        emit_member    = 1'b0;
        emit_value     = '0;
        emit_rel_valid = 1'b0;
        emit_last      = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    case (action_reg)
                        ACT_APPEND:
                        begin
                            ctrl.do_append = has_room;
                            emit           = 1'b1;
                            emit_status    = ~has_room;
                            if (has_room)
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ACT_REMOVE:
                        begin
                            ctrl.do_remove = 1'b1;
                            emit           = 1'b1;
                            emit_status    = ~found;
                            if (found)
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        ACT_MEMBER:
                        begin
                            emit        = 1'b1;
                            emit_member = found;
                        end
                        default:
                        begin
                            // Clear: an empty table answers at once.
                            count_next = '0;
                            emit       = ~dn_link[0].any_used;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (out_free)
                begin
                    ctrl.shift     = 1'b1;
                    emit           = dn_link[0].used;
                    emit_value     = dn_link[0].value;
                    emit_rel_valid = 1'b1;
                    emit_last      = ~rest_any;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action_t'(s_axis_tuser);
            key_reg    <= s_axis_tdata;
        end
        if (emit)
        begin
            out_status_reg    <= emit_status;
            out_member_reg    <= emit_member;
            out_value_reg     <= emit_value;
            out_rel_valid_reg <= emit_rel_valid;
            out_last_reg      <= emit_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - VALUE_W - 2){1'b0}},
                            out_value_reg, out_member_reg, out_status_reg};
    assign m_axis_tuser  = out_rel_valid_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // The count always agrees with the occupied marks outside a clear.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CLEAR) |-> ($countones(used_vec) == count_reg))
        else $error("entry count differs from occupied slots");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    // Once the final released entry leaves, the table is empty.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_rel_valid && emit_last) |=> !dn_link[0].any_used)
        else $error("table not empty after clear");

    // An append that reports success must have placed the value somewhere.
    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.do_append) |=> ($countones(used_vec) == $past(count_reg) + 1))
        else $error("append did not occupy exactly one slot");
`endif

endmodule

`default_nettype wire
